[src/pfbb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbb_pkg
// Shared types and constants of the page framebuffer bitmap blitter.
// ----------------------------------------------------------------------------
package pfbb_pkg;

	localparam int SCREEN_COLUMNS_DEF = 64;
	localparam int SCREEN_PAGES_DEF   = 8;
	localparam int BITMAP_BYTES_DEF   = 64;

	// widths sized for the largest legal parameter values
	localparam int COORD_W = 10;
	localparam int PG_W    = 4;
	localparam int FA_W    = 12;
	localparam int SB_W    = 12;
	localparam int BB_W    = SB_W - 3;
	localparam int QDEPTH  = 2;

	localparam logic [7:0] BYTE_MASK = 8'hff;

	localparam logic [2:0] ACT_CLEAR    = 3'd0;
	localparam logic [2:0] ACT_LOAD     = 3'd1;
	localparam logic [2:0] ACT_DRAW     = 3'd2;
	localparam logic [2:0] ACT_DRAW_ROT = 3'd3;
	localparam logic [2:0] ACT_READ     = 3'd4;

	typedef enum logic [2:0] {
		K_REPLY,
		K_CLEAR,
		K_LOAD,
		K_DRAW,
		K_READ
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic                err;
		logic                rot;
		logic                ld_ok;
		logic                rd_ok;
		logic [5:0]          bidx;
		logic [7:0]          bval;
		logic [FA_W-1:0]     faddr;
		logic [COORD_W-1:0]  x0;
		logic [COORD_W-1:0]  x_end;
		logic [COORD_W-1:0]  y0;
		logic [5:0]          h;
		logic [SB_W-1:0]     total;
		logic [PG_W-1:0]     p_first;
		logic [PG_W-1:0]     p_last;
	} cmd_t;

endpackage

[src/pfbb_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbb_front
// Takes a command word, checks ranges and sprite size, and works out the
// column and page bounds of a draw for the back end.
// ----------------------------------------------------------------------------
module pfbb_front #(
	parameter int SCREEN_COLUMNS = pfbb_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_PAGES   = pfbb_pkg::SCREEN_PAGES_DEF,
	parameter int BITMAP_BYTES   = pfbb_pkg::BITMAP_BYTES_DEF
) (
	input  logic             start,
	input  logic             busy,
	input  logic [2:0]       action,
	input  logic [5:0]       byte_index,
	input  logic [7:0]       byte_value,
	input  logic [5:0]       pos_x,
	input  logic [5:0]       pos_y,
	input  logic [5:0]       sprite_width,
	input  logic [5:0]       sprite_height,
	input  logic [2:0]       read_page,
	output logic             push,
	output pfbb_pkg::cmd_t   cmd
);

	localparam int ROWS = SCREEN_PAGES * 8;
	localparam int BITS = BITMAP_BYTES * 8;
	localparam logic [pfbb_pkg::COORD_W-1:0] COLS_C  = pfbb_pkg::COORD_W'(SCREEN_COLUMNS);
	localparam logic [pfbb_pkg::COORD_W-1:0] ROWS_C  = pfbb_pkg::COORD_W'(ROWS);
	localparam logic [pfbb_pkg::SB_W:0]      BITS_C  = (pfbb_pkg::SB_W + 1)'(BITS);
	localparam logic [pfbb_pkg::PG_W:0]      PAGES_C = (pfbb_pkg::PG_W + 1)'(SCREEN_PAGES);
	localparam logic [pfbb_pkg::PG_W-1:0]    PLAST_C = pfbb_pkg::PG_W'(SCREEN_PAGES - 1);
	localparam logic [pfbb_pkg::FA_W-1:0]    COLS_FA = pfbb_pkg::FA_W'(SCREEN_COLUMNS);
	localparam logic [pfbb_pkg::BB_W-1:0]    BYTES_C = pfbb_pkg::BB_W'(BITMAP_BYTES);

	logic [pfbb_pkg::COORD_W-1:0] x0, y0, xw, ylast;
	logic [pfbb_pkg::COORD_W-4:0] plast_raw;
	logic [pfbb_pkg::SB_W-1:0]    total;
	logic [pfbb_pkg::PG_W-1:0]    p_first, p_last;
	logic [pfbb_pkg::FA_W-1:0]    pbase0, rd_addr;
	logic                         empty_draw, too_big;

	assign push = start && !busy;

	always_comb begin
		x0 = pfbb_pkg::COORD_W'(pos_x);
		y0 = pfbb_pkg::COORD_W'(pos_y);
		total = pfbb_pkg::SB_W'(sprite_width) * pfbb_pkg::SB_W'(sprite_height);
		too_big = {1'b0, total} > BITS_C;
		empty_draw = (sprite_width == '0) || (sprite_height == '0) ||
			(x0 >= COLS_C) || (y0 >= ROWS_C);
		xw = x0 + pfbb_pkg::COORD_W'(sprite_width);
		// last pixel row of the sprite, meaningful only for a non-empty draw
		ylast = y0 + pfbb_pkg::COORD_W'(sprite_height) - pfbb_pkg::COORD_W'(1);
		plast_raw = ylast[pfbb_pkg::COORD_W-1:3];
		p_first = pfbb_pkg::PG_W'(pos_y[5:3]);
		p_last = (plast_raw > pfbb_pkg::COORD_W'(PLAST_C)) ? PLAST_C :
			pfbb_pkg::PG_W'(plast_raw);
		pbase0 = pfbb_pkg::FA_W'(p_first) * COLS_FA;
		rd_addr = pfbb_pkg::FA_W'(read_page) * COLS_FA + pfbb_pkg::FA_W'(pos_x);

		cmd = '0;
		cmd.bidx = byte_index;
		cmd.bval = byte_value;
		cmd.ld_ok = pfbb_pkg::BB_W'(byte_index) < BYTES_C;
		cmd.rd_ok = (x0 < COLS_C) && ((pfbb_pkg::PG_W + 1)'(read_page) < PAGES_C);
		cmd.x0 = x0;
		cmd.x_end = (xw < COLS_C) ? xw : COLS_C;
		cmd.y0 = y0;
		cmd.h = sprite_height;
		cmd.total = total;
		cmd.p_first = p_first;
		cmd.p_last = p_last;
		cmd.rot = (action == pfbb_pkg::ACT_DRAW_ROT);
		cmd.faddr = pbase0;
		unique case (action) inside
			pfbb_pkg::ACT_CLEAR: begin
				cmd.kind = pfbb_pkg::K_CLEAR;
			end
			pfbb_pkg::ACT_LOAD: begin
				cmd.kind = pfbb_pkg::K_LOAD;
			end
			pfbb_pkg::ACT_DRAW, pfbb_pkg::ACT_DRAW_ROT: begin
				// size check wins over an empty or off-screen sprite
				cmd.err = too_big;
				cmd.kind = (too_big || empty_draw) ? pfbb_pkg::K_REPLY : pfbb_pkg::K_DRAW;
			end
			pfbb_pkg::ACT_READ: begin
				cmd.kind = pfbb_pkg::K_READ;
				cmd.faddr = rd_addr;
			end
			default: begin
				cmd.kind = pfbb_pkg::K_REPLY;
			end
		endcase
	end

endmodule

[src/pfbb_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbb_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pfbb_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pfbb_pkg::cmd_t din,
	input  logic           pop,
	output pfbb_pkg::cmd_t head,
	output logic           full,
	output logic           empty
);

	localparam int PTR_W = $clog2(pfbb_pkg::QDEPTH);

	pfbb_pkg::cmd_t   entry_q [pfbb_pkg::QDEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [PTR_W:0]   cnt_q;

	assign head  = entry_q[rptr_q];
	assign full  = (cnt_q == (PTR_W + 1)'(pfbb_pkg::QDEPTH));
	assign empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(pfbb_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(pfbb_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= din;
		end
	end

`ifndef NO_ASSERTIONS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("command pushed into a full queue");
	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("command popped from an empty queue");
	a_first_word: assert property (@(posedge clk) disable iff (!arst_n)
		(push && empty) |=> (head == $past(din)))
		else $error("word pushed into an empty queue is not at its head");
`endif

endmodule

[src/pfbb_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbb_back
// Executes queued commands against the framebuffer and bitmap memories and
// produces one result word per command.
// ----------------------------------------------------------------------------
module pfbb_back #(
	parameter int SCREEN_COLUMNS = pfbb_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_PAGES   = pfbb_pkg::SCREEN_PAGES_DEF,
	parameter int BITMAP_BYTES   = pfbb_pkg::BITMAP_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  pfbb_pkg::cmd_t head,
	output logic           pop,
	output logic           init_busy,
	output logic           done,
	output logic [7:0]     read_data,
	output logic           size_error
);

	localparam int FRAME_BYTES = SCREEN_COLUMNS * SCREEN_PAGES;
	localparam int FAW         = $clog2(FRAME_BYTES);
	localparam int ROWS        = SCREEN_PAGES * 8;
	localparam int BANK_DEPTH  = (BITMAP_BYTES + 1) / 2;
	localparam int BKA_W       = $clog2(BANK_DEPTH);
	localparam logic [pfbb_pkg::FA_W-1:0]    COLS_FA = pfbb_pkg::FA_W'(SCREEN_COLUMNS);
	localparam logic [pfbb_pkg::COORD_W-1:0] ROWS_C  = pfbb_pkg::COORD_W'(ROWS);
	localparam logic [pfbb_pkg::BB_W-1:0]    BYTES_C = pfbb_pkg::BB_W'(BITMAP_BYTES);
	localparam logic [FAW-1:0]               CLR_LAST = FAW'(FRAME_BYTES - 1);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_CLEAR,
		S_DRAW,
		S_DRAIN,
		S_READ
	} state_t;

	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7 - i];
		end
		return r;
	endfunction

	state_t         state_q;
	logic [FAW-1:0] clr_q;
	logic           done_q, size_error_q;
	logic [7:0]     read_data_q;
	pfbb_pkg::cmd_t cmd_q;

	// draw walker: columns outer, pages inner
	logic [pfbb_pkg::COORD_W-1:0] x_q;
	logic [pfbb_pkg::PG_W-1:0]    p_q;
	logic [pfbb_pkg::FA_W-1:0]    pbase_q;
	logic [pfbb_pkg::SB_W-1:0]    colbase_q;

	// read stage of the draw pipeline
	logic           valid_s1, hi_ok_s1, lo_odd_s1;
	logic [FAW-1:0] faddr_s1;
	logic [2:0]     sh_s1, yoff_s1;
	logic [3:0]     n_s1;

	// memories
	logic [7:0]       frame_mem [FRAME_BYTES];
	logic [7:0]       ev_mem [BANK_DEPTH];
	logic [7:0]       od_mem [BANK_DEPTH];
	logic [7:0]       fr_rdata_q, ev_rdata_q, od_rdata_q;
	logic             fr_we, ev_we, od_we;
	logic [FAW-1:0]   fr_waddr, fr_raddr;
	logic [7:0]       fr_wdata;
	logic [BKA_W-1:0] bk_waddr, ev_raddr, od_raddr;

	// walker address math
	logic [pfbb_pkg::COORD_W-1:0] row_top, row_end, y_hi, ylo, yend, ndiff;
	logic [pfbb_pkg::SB_W-1:0]    r_lo, s_idx, l_idx;
	logic [pfbb_pkg::BB_W-1:0]    b_idx, b_next, ev_full, od_full, ld_full;
	logic [pfbb_pkg::FA_W-1:0]    it_faddr;
	logic [3:0]                   n_cur;
	logic                         last_pg, it_last, hi_ok;

	// merge stage
	logic [7:0]  lo_b, hi_b, nmask, pix, new_byte;
	logic [15:0] win;

	always_comb begin
		row_top = pfbb_pkg::COORD_W'({p_q, 3'b000});
		row_end = row_top + pfbb_pkg::COORD_W'(8);
		y_hi = cmd_q.y0 + pfbb_pkg::COORD_W'(cmd_q.h);
		ylo = (cmd_q.y0 > row_top) ? cmd_q.y0 : row_top;
		yend = y_hi;
		if (row_end < yend) begin
			yend = row_end;
		end
		if (ROWS_C < yend) begin
			yend = ROWS_C;
		end
		ndiff = yend - ylo;
		n_cur = ndiff[3:0];
		r_lo = pfbb_pkg::SB_W'(ylo - cmd_q.y0);
		s_idx = colbase_q + r_lo;
		// rotated: the page slice reads the mirrored run of stream bits
		l_idx = cmd_q.rot ? (cmd_q.total - s_idx - pfbb_pkg::SB_W'(n_cur)) : s_idx;
		b_idx = l_idx[pfbb_pkg::SB_W-1:3];
		b_next = b_idx + 1'b1;
		hi_ok = b_next < BYTES_C;
		// even bank holds bytes 0,2,4..; odd bank 1,3,5..
		ev_full = b_next >> 1;
		od_full = b_idx >> 1;
		it_faddr = pbase_q + pfbb_pkg::FA_W'(x_q);
		last_pg = (p_q == cmd_q.p_last);
		it_last = last_pg && ((x_q + 1'b1) == cmd_q.x_end);
	end

	always_comb begin
		lo_b = lo_odd_s1 ? od_rdata_q : ev_rdata_q;
		hi_b = hi_ok_s1 ? (lo_odd_s1 ? ev_rdata_q : od_rdata_q) : 8'h00;
		win = {hi_b, lo_b} >> sh_s1;
		nmask = pfbb_pkg::BYTE_MASK >> (4'd8 - n_s1);
		pix = win[7:0] & nmask;
		if (cmd_q.rot) begin
			pix = rev8(pix) >> (4'd8 - n_s1);
		end
		new_byte = fr_rdata_q | (pix << yoff_s1);
	end

	assign pop = (state_q == S_IDLE) && !empty;
	assign init_busy = (state_q == S_INIT);
	assign ld_full = pfbb_pkg::BB_W'(head.bidx[5:1]);

	always_comb begin
		fr_we = 1'b0;
		fr_waddr = faddr_s1;
		fr_wdata = new_byte;
		if (state_q == S_INIT || state_q == S_CLEAR) begin
			fr_we = 1'b1;
			fr_waddr = clr_q;
			fr_wdata = 8'h00;
		end else if (valid_s1) begin
			fr_we = 1'b1;
		end
		fr_raddr = (state_q == S_IDLE) ? head.faddr[FAW-1:0] : it_faddr[FAW-1:0];
		ev_we = pop && (head.kind == pfbb_pkg::K_LOAD) && head.ld_ok && !head.bidx[0];
		od_we = pop && (head.kind == pfbb_pkg::K_LOAD) && head.ld_ok && head.bidx[0];
		bk_waddr = ld_full[BKA_W-1:0];
		ev_raddr = ev_full[BKA_W-1:0];
		od_raddr = od_full[BKA_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (fr_we) begin
			frame_mem[fr_waddr] <= fr_wdata;
		end
		fr_rdata_q <= frame_mem[fr_raddr];
	end

	always_ff @(posedge clk) begin
		if (ev_we) begin
			ev_mem[bk_waddr] <= head.bval;
		end
		ev_rdata_q <= ev_mem[ev_raddr];
	end

	always_ff @(posedge clk) begin
		if (od_we) begin
			od_mem[bk_waddr] <= head.bval;
		end
		od_rdata_q <= od_mem[od_raddr];
	end

	// walker and pipeline payload
	always_ff @(posedge clk) begin
		faddr_s1  <= it_faddr[FAW-1:0];
		sh_s1     <= l_idx[2:0];
		yoff_s1   <= ylo[2:0];
		n_s1      <= n_cur;
		hi_ok_s1  <= hi_ok;
		lo_odd_s1 <= b_idx[0];
		if (pop) begin
			cmd_q     <= head;
			x_q       <= head.x0;
			p_q       <= head.p_first;
			pbase_q   <= head.faddr;
			colbase_q <= '0;
		end else if (state_q == S_DRAW) begin
			if (last_pg) begin
				x_q       <= x_q + 1'b1;
				p_q       <= cmd_q.p_first;
				pbase_q   <= cmd_q.faddr;
				colbase_q <= colbase_q + pfbb_pkg::SB_W'(cmd_q.h);
			end else begin
				p_q     <= p_q + 1'b1;
				pbase_q <= pbase_q + COLS_FA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			clr_q        <= '0;
			valid_s1     <= 1'b0;
			done_q       <= 1'b0;
			read_data_q  <= 8'h00;
			size_error_q <= 1'b0;
		end else begin
			done_q       <= 1'b0;
			read_data_q  <= 8'h00;
			size_error_q <= 1'b0;
			valid_s1     <= (state_q == S_DRAW);
			unique case (state_q)
				S_INIT: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						clr_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (!empty) begin
						unique case (head.kind)
							pfbb_pkg::K_CLEAR: begin
								clr_q   <= '0;
								state_q <= S_CLEAR;
							end
							pfbb_pkg::K_DRAW: begin
								state_q <= S_DRAW;
							end
							pfbb_pkg::K_READ: begin
								state_q <= S_READ;
							end
							default: begin
								done_q       <= 1'b1;
								size_error_q <= head.err;
							end
						endcase
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						clr_q   <= '0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DRAW: begin
					if (it_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_READ: begin
					done_q      <= 1'b1;
					read_data_q <= cmd_q.rd_ok ? fr_rdata_q : 8'h00;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign read_data  = read_data_q;
	assign size_error = size_error_q;

`ifndef NO_ASSERTIONS
	a_err_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		size_error |-> done) else $error("size error raised without a result");
	a_data_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		(read_data != 8'h00) |-> done) else $error("read data shown without a result");
	a_no_pop_pending: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !valid_s1) else $error("command taken while a draw write is pending");
	a_drain_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |=> done) else $error("draw finished without a result");
`endif

endmodule

[src/page_framebuffer_bitmap_blitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_bitmap_blitter
// Monochrome page framebuffer with a sprite store and an OR blitter.
// ----------------------------------------------------------------------------
// channel  | handshake                 | payload
// command  | start in, busy out        | action, byte_index, byte_value, pos_x,
//          |                           | pos_y, sprite_width, sprite_height,
//          |                           | read_page
// result   | done out, one cycle       | read_data, size_error
//
// a command word is taken on a clock edge with start high and busy low.
// a draw writes one framebuffer byte per cycle, walking the touched columns
// and touched pages; a clear sweeps all SCREEN_COLUMNS*SCREEN_PAGES bytes.
// after reset busy stays high while the framebuffer is swept to zero.
// a two-word queue takes commands while the back end works; results cannot
// be held off by the receiver.
// ----------------------------------------------------------------------------
module page_framebuffer_bitmap_blitter #(
	parameter int SCREEN_COLUMNS = pfbb_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_PAGES   = pfbb_pkg::SCREEN_PAGES_DEF,
	parameter int BITMAP_BYTES   = pfbb_pkg::BITMAP_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] action,
	input  logic [5:0] byte_index,
	input  logic [7:0] byte_value,
	input  logic [5:0] pos_x,
	input  logic [5:0] pos_y,
	input  logic [5:0] sprite_width,
	input  logic [5:0] sprite_height,
	input  logic [2:0] read_page,
	output logic       done,
	output logic [7:0] read_data,
	output logic       size_error
);

	pfbb_pkg::cmd_t new_cmd, head_cmd;
	logic           push, pop, q_full, q_empty, init_busy;

	assign busy = q_full || init_busy;

	pfbb_front #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_PAGES  (SCREEN_PAGES),
		.BITMAP_BYTES  (BITMAP_BYTES)
	) u_front (
		.start        (start),
		.busy         (busy),
		.action       (action),
		.byte_index   (byte_index),
		.byte_value   (byte_value),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.sprite_width (sprite_width),
		.sprite_height(sprite_height),
		.read_page    (read_page),
		.push         (push),
		.cmd          (new_cmd)
	);

	pfbb_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (new_cmd),
		.pop   (pop),
		.head  (head_cmd),
		.full  (q_full),
		.empty (q_empty)
	);

	pfbb_back #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_PAGES  (SCREEN_PAGES),
		.BITMAP_BYTES  (BITMAP_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.head      (head_cmd),
		.pop       (pop),
		.init_busy (init_busy),
		.done      (done),
		.read_data (read_data),
		.size_error(size_error)
	);

endmodule
